>>> rtl/core/assert_macros.svh
// assertion macros shared by the scheduler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define PSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication, masked during reset
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

>>> rtl/core/psd_pkg.sv
// types, codes and defaults for the priority scheduler with delays
// no dependencies; imported by psd_cell and the top level
package psd_pkg;

   localparam int THREAD_W = 6;
   localparam int TICKS_IN_W = 32;
   localparam int NUM_THREADS_DEF = 32;
   localparam int TICK_WIDTH_DEF = 32;
   localparam logic [THREAD_W-1:0] NO_THREAD = THREAD_W'(33);
   localparam logic [THREAD_W-1:0] IDLE_THREAD = '0;

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_DELAY    = 2'd1,
      OP_TICK     = 2'd2,
      OP_SCHEDULE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_INDEX  = 2'd1,
      STATUS_IDLE_DELAY = 2'd2,
      STATUS_ZERO_DELAY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_PICK
   } fsm_type;

   typedef struct packed {
      op_type                  op;
      logic [THREAD_W-1:0]     thread_index;
      logic [TICKS_IN_W-1:0]   delay_ticks;
   } req_type;

   typedef struct packed {
      logic [THREAD_W-1:0]     next_thread;
      logic                    switch_request;
      status_type              status;
   } rsp_type;

   // per-cell command strobes for the update cycle
   typedef struct packed {
      logic start;
      logic delay;
      logic tick;
   } cell_cmd_type;

endpackage

>>> rtl/core/psd_cell.sv
// one thread slot: ready, delayed and started flags plus its timeout counter
// depends on psd_pkg and assert_macros.svh
`include "assert_macros.svh"

module psd_cell #(
   parameter int TICK_WIDTH    = 32,
   parameter int THREAD_NUMBER = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psd_pkg::cell_cmd_type         cmd,
   input  logic [TICK_WIDTH-1:0]         ticks,
   input  logic [psd_pkg::THREAD_W-1:0]  best_in,
   output logic [psd_pkg::THREAD_W-1:0]  best_out,
   output logic                          registered
);
   import psd_pkg::*;

   logic                  ready_ff, ready_in;
   logic                  delayed_ff, delayed_in;
   logic                  registered_ff, registered_in;
   logic [TICK_WIDTH-1:0] timeout_ff, timeout_in;

   always_comb begin
      ready_in      = ready_ff;
      delayed_in    = delayed_ff;
      registered_in = registered_ff;
      timeout_in    = timeout_ff;
      if (cmd.start) begin
         registered_in = 1'b1;
         ready_in      = 1'b1;
      end
      if (cmd.delay) begin
         timeout_in = ticks;
         ready_in   = 1'b0;
         delayed_in = 1'b1;
      end
      if (cmd.tick && delayed_ff) begin
         if (timeout_ff <= TICK_WIDTH'(1)) begin
            timeout_in = '0;
            delayed_in = 1'b0;
            ready_in   = 1'b1;
         end else begin
            timeout_in = timeout_ff - TICK_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff      <= 1'b0;
         delayed_ff    <= 1'b0;
         registered_ff <= 1'b0;
      end else begin
         ready_ff      <= ready_in;
         delayed_ff    <= delayed_in;
         registered_ff <= registered_in;
      end
      timeout_ff <= timeout_in;
   end

   // a higher cell already claimed the slot, else offer our own index if ready
   assign best_out   = (best_in != '0) ? best_in :
                       (ready_ff ? THREAD_W'(THREAD_NUMBER) : '0);
   assign registered = registered_ff;

   `PSD_ASSERT_IMPL(a_ready_xor_delayed, clock, reset, ready_ff, !delayed_ff)
   `PSD_ASSERT_IMPL(a_delayed_nonzero, clock, reset, delayed_ff, timeout_ff != '0)
   `PSD_ASSERT_IMPL(a_ready_started, clock, reset, ready_ff, registered_ff)

endmodule

>>> rtl/core/priority_scheduler_with_delays_unit.sv
// top level of the fixed-priority scheduler with timed delays
// depends on psd_pkg, psd_cell and assert_macros.svh
//
// Each request passes the accept edge, then an update state in which
// every thread cell applies start, delay or tick to its own flags and counter
// at once, then a pick state in which the highest ready index ripples down
// the cell chain and the result is loaded into the output register. A new
// request is taken the cycle after that load; while the output register still
// holds an untaken result, the pick state repeats until it drains. Index 0 is
// idle and larger indices win; threads live in cells 1..NUM_THREADS, each
// with a TICK_WIDTH bit timeout, and current thread reads 33 after reset.
`include "assert_macros.svh"

module priority_scheduler_with_delays_unit #(
   parameter int NUM_THREADS = psd_pkg::NUM_THREADS_DEF,
   parameter int TICK_WIDTH  = psd_pkg::TICK_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psd_pkg::rsp_type rsp_payload
);
   import psd_pkg::*;

   // control
   fsm_type             state_ff, state_in;
   logic                do_update;
   logic                rsp_load;

   // latched request and its status
   req_type             req_ff;
   status_type          status_ff, status_in;
   logic [THREAD_W-1:0] current_ff, current_in;
   logic                idle_reg_ff, idle_reg_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // cell row
   cell_cmd_type        cmd       [NUM_THREADS];
   logic [THREAD_W-1:0] best      [NUM_THREADS+1];
   logic [NUM_THREADS-1:0] reg_vec;
   logic                reg_hit;
   logic [TICK_WIDTH-1:0] ticks_masked;
   logic                sched_op;

   assign ticks_masked = req_ff.delay_ticks[TICK_WIDTH-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_UPDATE;
         S_UPDATE: state_in = S_PICK;
         S_PICK:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      do_update = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_UPDATE: do_update = 1'b1;
         S_PICK:   rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   // is the requested start index already taken
   always_comb begin
      reg_hit = (req_ff.thread_index == IDLE_THREAD) && idle_reg_ff;
      for (int i = 0; i < NUM_THREADS; i++) begin
         if (req_ff.thread_index == THREAD_W'(i + 1) && reg_vec[i]) reg_hit = 1'b1;
      end
   end

   // refusal checks, the idle check before the zero-tick check
   always_comb begin
      status_in = STATUS_OK;
      unique case (req_ff.op)
         OP_START: begin
            if (req_ff.thread_index > THREAD_W'(NUM_THREADS) || reg_hit)
               status_in = STATUS_BAD_INDEX;
         end
         OP_DELAY: begin
            if (current_ff == IDLE_THREAD || current_ff > THREAD_W'(NUM_THREADS))
               status_in = STATUS_IDLE_DELAY;
            else if (ticks_masked == '0)
               status_in = STATUS_ZERO_DELAY;
         end
         default: status_in = STATUS_OK;
      endcase
   end

   // strobes to the cells during the update cycle
   always_comb begin
      for (int i = 0; i < NUM_THREADS; i++) begin
         cmd[i].start = do_update && req_ff.op == OP_START && status_in == STATUS_OK &&
                        req_ff.thread_index == THREAD_W'(i + 1);
         cmd[i].delay = do_update && req_ff.op == OP_DELAY && status_in == STATUS_OK &&
                        current_ff == THREAD_W'(i + 1);
         cmd[i].tick  = do_update && req_ff.op == OP_TICK;
      end
   end

   // idle is remembered as started but never made ready
   assign idle_reg_in = idle_reg_ff ||
                        (do_update && req_ff.op == OP_START && status_in == STATUS_OK &&
                         req_ff.thread_index == IDLE_THREAD);

   // highest ready index enters at the top of the chain and flows down
   assign best[NUM_THREADS] = '0;

   for (genvar g = 0; g < NUM_THREADS; g++) begin : g_cell
      psd_cell #(
         .TICK_WIDTH    (TICK_WIDTH),
         .THREAD_NUMBER (g + 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[g]),
         .ticks      (ticks_masked),
         .best_in    (best[g+1]),
         .best_out   (best[g]),
         .registered (reg_vec[g])
      );
   end

   // only an accepted delay or a schedule moves the current thread
   assign sched_op = (req_ff.op == OP_SCHEDULE) ||
                     (req_ff.op == OP_DELAY && status_ff == STATUS_OK);

   always_comb begin
      rsp_in.status = status_ff;
      if (sched_op) begin
         rsp_in.next_thread    = best[0];
         rsp_in.switch_request = best[0] != current_ff;
      end else begin
         rsp_in.next_thread    = current_ff;
         rsp_in.switch_request = 1'b0;
      end
      current_in   = (rsp_load && sched_op) ? best[0] : current_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         current_ff   <= NO_THREAD;
         idle_reg_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         current_ff   <= current_in;
         idle_reg_ff  <= idle_reg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && !req_stall) req_ff <= req_payload;
      if (do_update) status_ff <= status_in;
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `PSD_ASSERT_NEXT(a_switch_moves_current, clock, reset,
      rsp_load && rsp_in.switch_request, current_ff != $past(current_ff))
   `PSD_ASSERT_IMPL(a_refused_no_switch, clock, reset,
      rsp_load && status_ff != STATUS_OK, !rsp_in.switch_request)
   `PSD_ASSERT_IMPL(a_load_only_when_free, clock, reset,
      rsp_load, !(rsp_valid_ff && rsp_stall))

endmodule

>>> tb/priority_scheduler_with_delays_unit_test.sv
// self-checking bench for the fixed-priority scheduler with timed delays
// depends on psd_pkg and the priority_scheduler_with_delays_unit rtl
// a shadow of the kernel state predicts each decision; results are checked in order
module priority_scheduler_with_delays_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import psd_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int THREADS     = NUM_THREADS_DEF;
   localparam int TICK_W      = TICK_WIDTH_DEF;
   localparam int RANDOM_REQS = 270;   // per idling phase
   localparam int HOLD_CYCLES = 80;    // long receiver hold-off
   localparam int TIMEOUT_CYC = 200_000;

   // shadow of the scheduler: masks, timeouts and the running thread
   class kernel_shadow;
      logic [THREADS-1:0] ready_mask;
      logic [THREADS-1:0] delayed_mask;
      logic [THREADS:0]   started_mask;     // bit 0 is the idle thread
      logic [TICK_W-1:0]  timeout_left [THREADS];
      logic [THREAD_W-1:0] running_thread;
      rsp_type            pending_decisions [$];
      int                 mismatch_count;

      function new();
         ready_mask     = '0;
         delayed_mask   = '0;
         started_mask   = '0;
         running_thread = NO_THREAD;
         mismatch_count = 0;
         foreach (timeout_left[i]) timeout_left[i] = '0;
      endfunction

      // highest ready index wins, idle when nothing is ready
      function logic [THREAD_W-1:0] highest_ready();
         for (int i = THREADS; i >= 1; i--) begin
            if (ready_mask[i-1]) begin
               return THREAD_W'(i);
            end
         end
         return IDLE_THREAD;
      endfunction

      function void pick_next(inout rsp_type d);
         logic [THREAD_W-1:0] chosen;
         chosen           = highest_ready();
         d.next_thread    = chosen;
         d.switch_request = (chosen != running_thread);
         running_thread   = chosen;
      endfunction

      function void apply_kernel_op(req_type r);
         rsp_type            d;
         logic [TICK_W-1:0]  ticks;
         int                 slot;
         ticks            = r.delay_ticks[TICK_W-1:0];
         d.next_thread    = running_thread;
         d.switch_request = 1'b0;
         d.status         = STATUS_OK;
         case (r.op)
            OP_START: begin
               if (r.thread_index > THREADS || started_mask[r.thread_index]) begin
                  d.status = STATUS_BAD_INDEX;
               end else begin
                  started_mask[r.thread_index] = 1'b1;
                  if (r.thread_index != IDLE_THREAD) begin
                     ready_mask[r.thread_index-1] = 1'b1;
                  end
               end
            end
            OP_DELAY: begin
               // idle check comes before the zero-tick check
               if (running_thread == IDLE_THREAD || running_thread > THREADS) begin
                  d.status = STATUS_IDLE_DELAY;
               end else if (ticks == '0) begin
                  d.status = STATUS_ZERO_DELAY;
               end else begin
                  slot               = running_thread - 1;
                  timeout_left[slot] = ticks;
                  ready_mask[slot]   = 1'b0;
                  delayed_mask[slot] = 1'b1;
                  pick_next(d);
               end
            end
            OP_TICK: begin
               for (int i = 0; i < THREADS; i++) begin
                  if (delayed_mask[i]) begin
                     if (timeout_left[i] <= 1) begin
                        timeout_left[i] = '0;
                        delayed_mask[i] = 1'b0;
                        ready_mask[i]   = 1'b1;
                     end else begin
                        timeout_left[i] = timeout_left[i] - 1'b1;
                     end
                  end
               end
            end
            default: begin
               pick_next(d);
            end
         endcase
         pending_decisions.push_back(d);
      endfunction

      function void check_decision(rsp_type got);
         rsp_type want;
         if (pending_decisions.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            mismatch_count++;
            return;
         end
         want = pending_decisions.pop_front();
         if (got.next_thread !== want.next_thread) begin
            $error("next_thread: expected %0d, got %0d", want.next_thread, got.next_thread);
            mismatch_count++;
         end
         if (got.switch_request !== want.switch_request) begin
            $error("switch_request: expected %0b, got %0b",
                   want.switch_request, got.switch_request);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
         end
      endfunction

      function int outstanding();
         return pending_decisions.size();
      endfunction
   endclass

   // all inputs known from time zero
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   kernel_shadow tracker = new();

   // idling odds in percent, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off handshake between the main thread and the receiver
   int hold_asked = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   priority_scheduler_with_delays_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // sample both channels at the rising edge; a result taken in the same
   // cycle as a new request always belongs to an earlier request
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.apply_kernel_op(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_decision(rsp_payload);
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_seen) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // offer one request from a falling edge, return at the falling edge
   // after it has been taken
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   task automatic issue(input op_type op, input int idx, input logic [31:0] ticks);
      req_type r;
      r.op           = op;
      r.thread_index = THREAD_W'(idx);
      r.delay_ticks  = ticks;
      send_request(r);
   endtask

   // mostly well-formed traffic: starts in range, short delays, plenty of
   // ticks to release them; unused fields carry random noise
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.op = OP_START;
      end else if (pick < 40) begin
         r.op = OP_DELAY;
      end else if (pick < 70) begin
         r.op = OP_TICK;
      end else begin
         r.op = OP_SCHEDULE;
      end
      if (r.op == OP_START && $urandom_range(99) < 85) begin
         r.thread_index = THREAD_W'($urandom_range(THREADS));
      end else begin
         r.thread_index = THREAD_W'($urandom_range(63));
      end
      if (r.op == OP_DELAY) begin
         pick = $urandom_range(99);
         if (pick < 7) begin
            r.delay_ticks = '0;
         end else if (pick < 8) begin
            r.delay_ticks = $urandom();   // parks the thread for good
         end else if (pick < 85) begin
            r.delay_ticks = $urandom_range(6, 1);
         end else begin
            r.delay_ticks = $urandom_range(40, 7);
         end
      end else begin
         r.delay_ticks = $urandom();
      end
      return r;
   endfunction

   task automatic random_phase(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (RANDOM_REQS) send_request(random_request());
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: refusals straight after reset, idle handling, bad indices
      issue(OP_DELAY, 0, 32'd5);              // no thread running yet
      issue(OP_SCHEDULE, 0, 32'd0);           // nothing ready, idle chosen
      issue(OP_SCHEDULE, 63, 32'hFFFF_FFFF);  // idle again, no switch
      issue(OP_DELAY, 0, 32'd3);              // delay from idle
      issue(OP_START, 0, 32'd0);              // idle registers, never ready
      issue(OP_START, 0, 32'd0);              // already registered
      issue(OP_START, 33, 32'd0);             // just past the top index
      issue(OP_START, 63, 32'd0);             // all index bits set
      issue(OP_START, 1, 32'd0);
      issue(OP_START, 32, 32'd0);
      issue(OP_START, 17, 32'd0);
      issue(OP_START, 1, 32'd0);              // used index
      issue(OP_TICK, 42, 32'h5555_5555);      // nothing delayed yet
      issue(OP_SCHEDULE, 0, 32'd0);           // highest index wins
      issue(OP_DELAY, 0, 32'd0);              // zero ticks refused
      issue(OP_DELAY, 21, 32'd2);             // top thread sleeps, 17 runs
      issue(OP_DELAY, 0, 32'hFFFF_FFFF);      // longest delay parks 17
      issue(OP_DELAY, 0, 32'd1);              // lowest thread sleeps, idle runs
      issue(OP_DELAY, 0, 32'd4);              // delay from idle
      issue(OP_TICK, 0, 32'hAAAA_AAAA);       // thread 1 wakes, 32 counts down
      issue(OP_SCHEDULE, 0, 32'd0);           // thread 1 back
      issue(OP_TICK, 0, 32'd0);               // thread 32 wakes
      issue(OP_SCHEDULE, 0, 32'd0);           // thread 32 pre-empts

      // random traffic under three idling patterns
      random_phase(18, 57);
      random_phase(57, 18);

      // receiver holds off while the sender keeps offering, so the output
      // register fills and the request channel stalls
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked    = hold_asked + 1;
      repeat (12) send_request(random_request());
      random_phase(0, 0);
      req_valid <= 1'b0;

      // drain, then wait for anything stray
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYC);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> priority_scheduler_with_delays_unit.f
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_cell.sv
rtl/core/priority_scheduler_with_delays_unit.sv
tb/priority_scheduler_with_delays_unit_test.sv
